FILE: rtl/slt_pkg.sv
// Shared constants, types and byte-class helpers of the source lexer token scanner.
`default_nettype none

package slt_pkg;

	// Defaults of the top-level parameters.
	localparam int unsigned OFFSET_BITS_DEF   = 16;
	localparam int unsigned LINE_BITS_DEF     = 16;
	localparam int unsigned COLUMN_BITS_DEF   = 12;
	localparam int unsigned KEYWORD_CHARS_DEF = 6;
	localparam int unsigned QUEUE_DEPTH_DEF   = 4;

	// One accepted byte gives at most three tokens.
	localparam int unsigned KIND_W     = 5;
	localparam int unsigned SLOTS      = 3;
	localparam int unsigned SLOT_CNT_W = 2;

	// Token kinds.
	localparam logic [KIND_W-1:0] KIND_LPAREN = 5'd0;
	localparam logic [KIND_W-1:0] KIND_RPAREN = 5'd1;
	localparam logic [KIND_W-1:0] KIND_LBRACE = 5'd2;
	localparam logic [KIND_W-1:0] KIND_RBRACE = 5'd3;
	localparam logic [KIND_W-1:0] KIND_PLUS   = 5'd4;
	localparam logic [KIND_W-1:0] KIND_MINUS  = 5'd5;
	localparam logic [KIND_W-1:0] KIND_STAR   = 5'd6;
	localparam logic [KIND_W-1:0] KIND_SLASH  = 5'd7;
	localparam logic [KIND_W-1:0] KIND_EQUALS = 5'd8;
	localparam logic [KIND_W-1:0] KIND_COMMA  = 5'd9;
	localparam logic [KIND_W-1:0] KIND_IDENT  = 5'd10;
	localparam logic [KIND_W-1:0] KIND_FUNC   = 5'd11;
	localparam logic [KIND_W-1:0] KIND_LET    = 5'd12;
	localparam logic [KIND_W-1:0] KIND_IF     = 5'd13;
	localparam logic [KIND_W-1:0] KIND_ELSE   = 5'd14;
	localparam logic [KIND_W-1:0] KIND_RETURN = 5'd15;
	localparam logic [KIND_W-1:0] KIND_NUMBER = 5'd16;
	localparam logic [KIND_W-1:0] KIND_STRING = 5'd17;
	localparam logic [KIND_W-1:0] KIND_EOF    = 5'd18;
	localparam logic [KIND_W-1:0] KIND_UNTERM = 5'd19;

	// Keywords, last character in the lowest byte.
	localparam logic [63:0] KW_FUNC   = 64'h0000_0000_6675_6E63;
	localparam logic [63:0] KW_LET    = 64'h0000_0000_006C_6574;
	localparam logic [63:0] KW_IF     = 64'h0000_0000_0000_6966;
	localparam logic [63:0] KW_ELSE   = 64'h0000_0000_656C_7365;
	localparam logic [63:0] KW_RETURN = 64'h0000_7265_7475_726E;

	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_QUOTE   = 8'h22;

	typedef struct packed {
		logic              hit;
		logic [KIND_W-1:0] kind;
	} slt_op_t;

	// Queue status seen by the scanner and the output stage.
	typedef struct packed {
		logic full;
		logic empty;
	} slt_q_stat_t;

	// Scanner status.
	typedef struct packed {
		logic idle;
	} slt_front_stat_t;

	function automatic slt_op_t op_lookup(input logic [7:0] c);
		slt_op_t r;
		r.hit = 1'b1;
		case (c)
			8'h28:   r.kind = KIND_LPAREN;
			8'h29:   r.kind = KIND_RPAREN;
			8'h7B:   r.kind = KIND_LBRACE;
			8'h7D:   r.kind = KIND_RBRACE;
			8'h2B:   r.kind = KIND_PLUS;
			8'h2D:   r.kind = KIND_MINUS;
			8'h2A:   r.kind = KIND_STAR;
			8'h2F:   r.kind = KIND_SLASH;
			8'h3D:   r.kind = KIND_EQUALS;
			8'h2C:   r.kind = KIND_COMMA;
			default: begin
				r.hit  = 1'b0;
				r.kind = KIND_LPAREN;
			end
		endcase
		return r;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/slt_front.sv
// Scanner front end: accepts bytes, tracks position and token state, builds token bundles.
`default_nettype none

module slt_front
	import slt_pkg::*;
#(
	parameter int unsigned OFFSET_BITS   = OFFSET_BITS_DEF,
	parameter int unsigned LINE_BITS     = LINE_BITS_DEF,
	parameter int unsigned COLUMN_BITS   = COLUMN_BITS_DEF,
	parameter int unsigned KEYWORD_CHARS = KEYWORD_CHARS_DEF,
	localparam int unsigned TOK_W = KIND_W + LINE_BITS + COLUMN_BITS + 2 * OFFSET_BITS,
	localparam int unsigned BUN_W = SLOT_CNT_W + SLOTS * TOK_W
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [7:0]      in_byte,
	input  wire logic            in_has_byte,
	input  wire logic            in_final,
	input  wire slt_q_stat_t     q_stat,
	output logic                 push,
	output logic [BUN_W-1:0]     push_data,
	output slt_front_stat_t      stat
);

	localparam int unsigned KBUF_W = 8 * KEYWORD_CHARS;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_INT,
		MODE_FRAC,
		MODE_STRING
	} mode_t;

	mode_t                  mode_q, nx_mode;
	logic [LINE_BITS-1:0]   line_q, nx_line, sline_q, nx_sline;
	logic [COLUMN_BITS-1:0] col_q, nx_col, scol_q, nx_scol;
	logic [OFFSET_BITS-1:0] off_q, nx_off, soff_q, nx_soff;
	logic [OFFSET_BITS-1:0] run_q, nx_run;
	logic [KBUF_W-1:0]      kbuf_q, nx_kbuf;

	logic                   accept;
	logic                   used;
	logic                   ident_ch;
	slt_op_t                op;
	logic [KIND_W-1:0]      close_kind, open_kind;
	logic                   cand_v [4];
	logic [TOK_W-1:0]       cand [4];
	logic [SLOT_CNT_W-1:0]  cnt;
	logic [SLOTS*TOK_W-1:0] slots;

	function automatic logic [KIND_W-1:0] ident_kind(input logic [OFFSET_BITS-1:0] run,
			input logic [KBUF_W-1:0] kb);
		logic [KIND_W-1:0] k;
		k = KIND_IDENT;
		if (run == OFFSET_BITS'(4) && kb == KW_FUNC[KBUF_W-1:0])   k = KIND_FUNC;
		if (run == OFFSET_BITS'(3) && kb == KW_LET[KBUF_W-1:0])    k = KIND_LET;
		if (run == OFFSET_BITS'(2) && kb == KW_IF[KBUF_W-1:0])     k = KIND_IF;
		if (run == OFFSET_BITS'(4) && kb == KW_ELSE[KBUF_W-1:0])   k = KIND_ELSE;
		if (run == OFFSET_BITS'(6) && kb == KW_RETURN[KBUF_W-1:0]) k = KIND_RETURN;
		return k;
	endfunction

	function automatic logic [TOK_W-1:0] mk_tok(input logic [KIND_W-1:0] kind,
			input logic [LINE_BITS-1:0] ln, input logic [COLUMN_BITS-1:0] cl,
			input logic [OFFSET_BITS-1:0] of, input logic [OFFSET_BITS-1:0] len);
		return {len, of, cl, ln, kind};
	endfunction

	assign in_ready  = !q_stat.full;
	assign accept    = in_valid && in_ready;
	assign stat.idle = (mode_q == MODE_IDLE);
	assign op        = op_lookup(in_byte);
	assign ident_ch  = is_alpha(in_byte) || is_digit(in_byte) || in_byte == CH_UNDER;

	always_comb begin
		nx_mode    = mode_q;
		nx_line    = line_q;
		nx_col     = col_q;
		nx_off     = off_q;
		nx_sline   = sline_q;
		nx_scol    = scol_q;
		nx_soff    = soff_q;
		nx_run     = run_q;
		nx_kbuf    = kbuf_q;
		used       = 1'b0;
		cand_v[0]  = 1'b0;
		cand_v[1]  = 1'b0;
		close_kind = KIND_IDENT;

		if (in_has_byte) begin
			case (mode_q)
				MODE_IDENT: begin
					if (ident_ch) begin
						nx_run  = (run_q == '1) ? run_q : run_q + 1'b1;
						nx_kbuf = {kbuf_q[KBUF_W-9:0], in_byte};
						used    = 1'b1;
					end else begin
						cand_v[0]  = 1'b1;
						close_kind = ident_kind(run_q, kbuf_q);
						nx_mode    = MODE_IDLE;
					end
				end
				MODE_INT, MODE_FRAC: begin
					if (is_digit(in_byte) || (mode_q == MODE_INT && in_byte == CH_DOT)) begin
						if (in_byte == CH_DOT) nx_mode = MODE_FRAC;
						nx_run = (run_q == '1) ? run_q : run_q + 1'b1;
						used   = 1'b1;
					end else begin
						cand_v[0]  = 1'b1;
						close_kind = KIND_NUMBER;
						nx_mode    = MODE_IDLE;
					end
				end
				MODE_STRING: begin
					if (in_byte == CH_QUOTE) begin
						cand_v[0]  = 1'b1;
						close_kind = KIND_STRING;
						nx_mode    = MODE_IDLE;
					end else begin
						nx_run = (run_q == '1) ? run_q : run_q + 1'b1;
					end
					used = 1'b1;
				end
				default: nx_mode = MODE_IDLE;
			endcase

			if (!used) begin
				if (op.hit) begin
					cand_v[1] = 1'b1;
				end else if (is_alpha(in_byte) || in_byte == CH_UNDER) begin
					nx_mode  = MODE_IDENT;
					nx_sline = line_q;
					nx_scol  = col_q;
					nx_soff  = off_q;
					nx_run   = OFFSET_BITS'(1);
					nx_kbuf  = KBUF_W'(in_byte);
				end else if (is_digit(in_byte)) begin
					nx_mode  = MODE_INT;
					nx_sline = line_q;
					nx_scol  = col_q;
					nx_soff  = off_q;
					nx_run   = OFFSET_BITS'(1);
				end else if (in_byte == CH_QUOTE) begin
					nx_mode  = MODE_STRING;
					nx_sline = line_q;
					nx_scol  = col_q;
					nx_soff  = (off_q == '1) ? off_q : off_q + 1'b1;
					nx_run   = '0;
				end
			end

			if (in_byte == CH_NEWLINE) begin
				nx_line = (line_q == '1) ? line_q : line_q + 1'b1;
				nx_col  = COLUMN_BITS'(1);
			end else begin
				nx_col  = (col_q == '1) ? col_q : col_q + 1'b1;
			end
			nx_off = (off_q == '1) ? off_q : off_q + 1'b1;
		end

		// Token still open at the end of the source.
		case (nx_mode)
			MODE_IDENT:          open_kind = ident_kind(nx_run, nx_kbuf);
			MODE_INT, MODE_FRAC: open_kind = KIND_NUMBER;
			MODE_STRING:         open_kind = KIND_UNTERM;
			default:             open_kind = KIND_IDENT;
		endcase
		cand_v[2] = in_final && nx_mode != MODE_IDLE;
		cand_v[3] = in_final && nx_mode != MODE_STRING;

		cand[0] = mk_tok(close_kind, sline_q, scol_q, soff_q, run_q);
		cand[1] = mk_tok(op.kind, line_q, col_q, off_q, OFFSET_BITS'(1));
		cand[2] = mk_tok(open_kind, nx_sline, nx_scol, nx_soff, nx_run);
		cand[3] = mk_tok(KIND_EOF, nx_line, nx_col, nx_off, '0);

		// Pack the tokens that fire into the lowest slots, in order.
		cnt   = '0;
		slots = '0;
		for (int i = 0; i < 4; i++) begin
			if (cand_v[i] && cnt < SLOT_CNT_W'(SLOTS)) begin
				slots[cnt*TOK_W +: TOK_W] = cand[i];
				cnt = cnt + 1'b1;
			end
		end
	end

	assign push      = accept && cnt != '0;
	assign push_data = {cnt, slots};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			line_q  <= LINE_BITS'(1);
			col_q   <= COLUMN_BITS'(1);
			off_q   <= '0;
			sline_q <= LINE_BITS'(1);
			scol_q  <= COLUMN_BITS'(1);
			soff_q  <= '0;
			run_q   <= '0;
			kbuf_q  <= '0;
		end else if (accept) begin
			if (in_final) begin
				mode_q  <= MODE_IDLE;
				line_q  <= LINE_BITS'(1);
				col_q   <= COLUMN_BITS'(1);
				off_q   <= '0;
				sline_q <= LINE_BITS'(1);
				scol_q  <= COLUMN_BITS'(1);
				soff_q  <= '0;
				run_q   <= '0;
				kbuf_q  <= '0;
			end else begin
				mode_q  <= nx_mode;
				line_q  <= nx_line;
				col_q   <= nx_col;
				off_q   <= nx_off;
				sline_q <= nx_sline;
				scol_q  <= nx_scol;
				soff_q  <= nx_soff;
				run_q   <= nx_run;
				kbuf_q  <= nx_kbuf;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/slt_queue.sv
// Short register queue of token bundles between the scanner and the output stage.
`default_nettype none

module slt_queue
	import slt_pkg::*;
#(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      head,
	output slt_q_stat_t           stat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/slt_back.sv
// Output stage: walks the tokens of each queued bundle into the output register.
`default_nettype none

module slt_back
	import slt_pkg::*;
#(
	parameter int unsigned TOK_W  = 64,
	parameter int unsigned DATA_W = 64,
	localparam int unsigned BUN_W = SLOT_CNT_W + SLOTS * TOK_W
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [BUN_W-1:0]  head,
	input  wire slt_q_stat_t       q_stat,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [DATA_W-1:0]      out_data,
	output logic [KIND_W-1:0]      out_kind,
	output logic                   out_last
);

	logic [SLOT_CNT_W-1:0] sel_q;
	logic [SLOT_CNT_W-1:0] head_cnt;
	logic [TOK_W-1:0]      tok;
	logic                  load;
	logic                  at_end;
	logic                  valid_q;
	logic [DATA_W-1:0]     data_q;
	logic [KIND_W-1:0]     kind_q;
	logic                  last_q;

	assign head_cnt = head[BUN_W-1 -: SLOT_CNT_W];
	assign tok      = head[sel_q*TOK_W +: TOK_W];
	assign at_end   = (sel_q == head_cnt - 1'b1);
	assign load     = !q_stat.empty && (!valid_q || out_ready);
	assign pop      = load && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			sel_q   <= at_end ? '0 : sel_q + 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= DATA_W'(tok[TOK_W-1:KIND_W]);
			kind_q <= tok[KIND_W-1:0];
			last_q <= at_end;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_kind  = kind_q;
	assign out_last  = last_q;

endmodule

`default_nettype wire

FILE: rtl/source_lexer_token_scanner.sv
// Top level of the source lexer token scanner: byte stream in, token stream out.
//
// Channel  Dir  Handshake          Contents
// s_*      in   s_tvalid/s_tready  tdata: source byte; tuser: byte present; tlast: end of source
// m_*      out  m_tvalid/m_tready  tdata: line, column, offset, length; tuser: kind; tlast: last
//
// A byte is taken in every cycle while the token queue has room, and its position and
// token state are updated in that same cycle. Tokens leave at one per cycle from the
// output register while m_tready is high, so a byte that closes a token and is itself an
// operator, or the end of the source, can give up to three tokens, which leave one after
// another. A token passes through the queue entry and then the output register before
// it reaches m_tvalid.
// Reset clears the scan state, the queue pointers and the output valid; no clearing pass
// is needed. A stall on m_tready fills the queue, after which s_tready falls.
`default_nettype none

module source_lexer_token_scanner
	import slt_pkg::*;
#(
	parameter int unsigned OFFSET_BITS   = OFFSET_BITS_DEF,
	parameter int unsigned LINE_BITS     = LINE_BITS_DEF,
	parameter int unsigned COLUMN_BITS   = COLUMN_BITS_DEF,
	parameter int unsigned KEYWORD_CHARS = KEYWORD_CHARS_DEF,
	parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
	localparam int unsigned DATA_W = ((LINE_BITS + COLUMN_BITS + 2 * OFFSET_BITS + 7) / 8) * 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [7:0]        s_tdata,   // [7:0] source_byte
	input  wire logic              s_tuser,   // [0] has_byte
	input  wire logic              s_tlast,   // is_final
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [DATA_W-1:0]      m_tdata,   // token_line, token_column, token_offset,
	                                          // token_length, then zero fill
	output logic [KIND_W-1:0]      m_tuser,   // [4:0] token_kind
	output logic                   m_tlast    // last_of_run
);

	localparam int unsigned TOK_W = KIND_W + LINE_BITS + COLUMN_BITS + 2 * OFFSET_BITS;
	localparam int unsigned BUN_W = SLOT_CNT_W + SLOTS * TOK_W;

	slt_q_stat_t     q_stat;
	slt_front_stat_t front_stat;
	logic            q_push, q_pop;
	logic [BUN_W-1:0] q_push_data, q_head;

	// The front end classifies each byte and packs up to three tokens into one bundle.
	slt_front #(
		.OFFSET_BITS   (OFFSET_BITS),
		.LINE_BITS     (LINE_BITS),
		.COLUMN_BITS   (COLUMN_BITS),
		.KEYWORD_CHARS (KEYWORD_CHARS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_byte     (s_tdata),
		.in_has_byte (s_tuser),
		.in_final    (s_tlast),
		.q_stat      (q_stat),
		.push        (q_push),
		.push_data   (q_push_data),
		.stat        (front_stat)
	);

	// The queue lets the scanner run ahead while the output side is stalled.
	slt_queue #(
		.WIDTH (BUN_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	// The back end hands the tokens of each bundle out one transfer at a time.
	slt_back #(
		.TOK_W  (TOK_W),
		.DATA_W (DATA_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_stat    (q_stat),
		.pop       (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_kind  (m_tuser),
		.out_last  (m_tlast)
	);

`ifndef NO_ASSERTIONS
	// A bundle is only written when there is room for it.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("token bundle written into a full queue");

	// A bundle is only removed when the queue holds one.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("token bundle removed from an empty queue");

	// The end of the source always produces at least one token.
	a_final_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |-> q_push)
		else $error("end of source gave no token");

	// After the end of the source the scanner is back in its idle mode.
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> front_stat.idle)
		else $error("scanner not idle after end of source");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_source_lexer_token_scanner.sv
// Self-checking testbench for the source lexer token scanner: byte stream in, token stream out.
`timescale 1ns / 1ps

module tb_source_lexer_token_scanner;
	import slt_pkg::*;

	// Field widths of the instance under test, which keeps its default parameters.
	localparam int unsigned LINE_W  = LINE_BITS_DEF;
	localparam int unsigned COL_W   = COLUMN_BITS_DEF;
	localparam int unsigned OFF_W   = OFFSET_BITS_DEF;
	localparam int unsigned KBUF_W  = 8 * KEYWORD_CHARS_DEF;
	localparam int unsigned FIELD_W = LINE_W + COL_W + 2 * OFF_W;
	localparam int unsigned TDATA_W = ((FIELD_W + 7) / 8) * 8;

	// Cycles without any transfer on either side before the run is abandoned. The longest
	// legal quiet stretch is the deliberate receiver hold-off below.
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_ITEMS = 470;

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_IDENT,
		SCAN_INT,
		SCAN_FRAC,
		SCAN_STRING
	} scan_mode_t;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [LINE_W-1:0] line;
		logic [COL_W-1:0]  column;
		logic [OFF_W-1:0]  offset;
		logic [OFF_W-1:0]  length;
		logic              last;
	} token_t;

	// The scoreboard carries its own copy of the scanner state. Each accepted transfer on
	// the input side is run through the same rules as the block and the tokens it should
	// produce are queued; each token leaving the block is compared with the oldest one.
	class token_scoreboard;
		scan_mode_t        mode;
		logic [LINE_W-1:0] line_now, start_line;
		logic [COL_W-1:0]  column_now, start_column;
		logic [OFF_W-1:0]  offset_now, start_offset, run_len;
		logic [KBUF_W-1:0] word_tail;
		token_t            expected_tokens[$];
		int                errors, tokens_checked, bytes_seen, sources_seen, unterminated_seen;
		bit [19:0]         kinds_seen;

		function new();
			restart();
		endfunction

		function void restart();
			mode         = SCAN_IDLE;
			line_now     = 1;
			column_now   = 1;
			offset_now   = 0;
			start_line   = 1;
			start_column = 1;
			start_offset = 0;
			run_len      = 0;
			word_tail    = 0;
		endfunction

		function logic [LINE_W-1:0] bump_line(logic [LINE_W-1:0] v);
			return (&v) ? v : v + 1'b1;
		endfunction

		function logic [COL_W-1:0] bump_col(logic [COL_W-1:0] v);
			return (&v) ? v : v + 1'b1;
		endfunction

		function logic [OFF_W-1:0] bump_off(logic [OFF_W-1:0] v);
			return (&v) ? v : v + 1'b1;
		endfunction

		function bit letter(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		endfunction

		function bit numeral(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function bit operator_of(logic [7:0] c, output logic [KIND_W-1:0] k);
			k = KIND_LPAREN;
			case (c)
				"(": k = KIND_LPAREN;
				")": k = KIND_RPAREN;
				"{": k = KIND_LBRACE;
				"}": k = KIND_RBRACE;
				"+": k = KIND_PLUS;
				"-": k = KIND_MINUS;
				"*": k = KIND_STAR;
				"/": k = KIND_SLASH;
				"=": k = KIND_EQUALS;
				",": k = KIND_COMMA;
				default: return 1'b0;
			endcase
			return 1'b1;
		endfunction

		// An identifier is a keyword only when its length and its retained tail both match.
		function logic [KIND_W-1:0] word_kind();
			if (run_len > KEYWORD_CHARS_DEF)
				return KIND_IDENT;
			if (run_len == 4 && word_tail == KW_FUNC[KBUF_W-1:0])
				return KIND_FUNC;
			if (run_len == 3 && word_tail == KW_LET[KBUF_W-1:0])
				return KIND_LET;
			if (run_len == 2 && word_tail == KW_IF[KBUF_W-1:0])
				return KIND_IF;
			if (run_len == 4 && word_tail == KW_ELSE[KBUF_W-1:0])
				return KIND_ELSE;
			if (run_len == 6 && word_tail == KW_RETURN[KBUF_W-1:0])
				return KIND_RETURN;
			return KIND_IDENT;
		endfunction

		function void push_token(logic [KIND_W-1:0] kind, logic [LINE_W-1:0] line,
				logic [COL_W-1:0] column, logic [OFF_W-1:0] offset, logic [OFF_W-1:0] length);
			token_t t;
			t.kind   = kind;
			t.line   = line;
			t.column = column;
			t.offset = offset;
			t.length = length;
			t.last   = 1'b0;
			expected_tokens.insert(expected_tokens.size(), t);
		endfunction

		function void close_open(logic [KIND_W-1:0] kind);
			push_token(kind, start_line, start_column, start_offset, run_len);
		endfunction

		function void open_token(scan_mode_t m, logic [OFF_W-1:0] offset);
			mode         = m;
			start_line   = line_now;
			start_column = column_now;
			start_offset = offset;
		endfunction

		function void note_byte(logic [7:0] c, logic has, logic fin);
			logic [KIND_W-1:0] op;
			bit                used;
			int                queued;
			token_t            t;
			queued = expected_tokens.size();
			if (has) begin
				bytes_seen++;
				used = 1'b0;
				case (mode)
					SCAN_IDENT: begin
						if (letter(c) || numeral(c) || c == CH_UNDER) begin
							run_len   = bump_off(run_len);
							word_tail = {word_tail[KBUF_W-9:0], c};
							used      = 1'b1;
						end else begin
							close_open(word_kind());
							mode = SCAN_IDLE;
						end
					end
					SCAN_INT, SCAN_FRAC: begin
						if (numeral(c) || (mode == SCAN_INT && c == CH_DOT)) begin
							if (c == CH_DOT)
								mode = SCAN_FRAC;
							run_len = bump_off(run_len);
							used    = 1'b1;
						end else begin
							close_open(KIND_NUMBER);
							mode = SCAN_IDLE;
						end
					end
					SCAN_STRING: begin
						if (c == CH_QUOTE) begin
							close_open(KIND_STRING);
							mode = SCAN_IDLE;
						end else begin
							run_len = bump_off(run_len);
						end
						used = 1'b1;
					end
					default: mode = SCAN_IDLE;
				endcase
				// A byte that ended a token is looked at again as if nothing were open.
				if (!used) begin
					if (operator_of(c, op)) begin
						push_token(op, line_now, column_now, offset_now, 1);
					end else if (letter(c) || c == CH_UNDER) begin
						open_token(SCAN_IDENT, offset_now);
						run_len   = 1;
						word_tail = KBUF_W'(c);
					end else if (numeral(c)) begin
						open_token(SCAN_INT, offset_now);
						run_len = 1;
					end else if (c == CH_QUOTE) begin
						open_token(SCAN_STRING, bump_off(offset_now));
						run_len = 0;
					end
				end
				if (c == CH_NEWLINE) begin
					line_now   = bump_line(line_now);
					column_now = 1;
				end else begin
					column_now = bump_col(column_now);
				end
				offset_now = bump_off(offset_now);
			end
			if (fin) begin
				sources_seen++;
				case (mode)
					SCAN_IDENT:          close_open(word_kind());
					SCAN_INT, SCAN_FRAC: close_open(KIND_NUMBER);
					SCAN_STRING: begin
						close_open(KIND_UNTERM);
						unterminated_seen++;
					end
					default: ;
				endcase
				// An open string replaces the end-of-file token with the error token.
				if (mode != SCAN_STRING)
					push_token(KIND_EOF, line_now, column_now, offset_now, 0);
				restart();
			end
			if (expected_tokens.size() > queued) begin
				t      = expected_tokens.pop_back();
				t.last = 1'b1;
				expected_tokens.insert(expected_tokens.size(), t);
			end
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_token(logic [KIND_W-1:0] kind, logic [TDATA_W-1:0] data, logic last);
			token_t want;
			if (expected_tokens.size() == 0) begin
				$error("token with none expected: kind %0d, data %h", kind, data);
				errors++;
				return;
			end
			want = expected_tokens.pop_front();
			tokens_checked++;
			kinds_seen[want.kind] = 1'b1;
			compare("token_kind", want.kind, kind);
			compare("token_line", want.line, data[LINE_W-1:0]);
			compare("token_column", want.column, data[LINE_W+COL_W-1:LINE_W]);
			compare("token_offset", want.offset, data[LINE_W+COL_W+OFF_W-1:LINE_W+COL_W]);
			compare("token_length", want.length, data[FIELD_W-1:LINE_W+COL_W+OFF_W]);
			compare("tdata zero fill", 0, data[TDATA_W-1:FIELD_W]);
			compare("last_of_run", want.last, last);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = 8'h00;
	logic               s_tuser = 1'b0;
	logic               s_tlast = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic [KIND_W-1:0]  m_tuser;
	logic               m_tlast;

	token_scoreboard sb;
	int  src_gap;          // chance in percent of an idle burst before a transfer
	int  sink_gap;         // chance in percent of a receiver stall burst
	bit  hold_off;         // asks the receiver for one long hold-off
	int  holds_done;
	int  items_sent;
	int  quiet_cycles;

	string keywords[5] = '{"func", "let", "if", "else", "return"};
	string op_chars    = "(){}+-*/=,";

	source_lexer_token_scanner u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	// Both monitors sample at the rising edge, before any register behind them has moved.
	// A token always passes through the queue and the output register after its byte is
	// taken, so noting the input before checking the output at the same edge is safe.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_byte(s_tdata, s_tuser, s_tlast);
		if (arst_n && m_tvalid && m_tready)
			sb.check_token(m_tuser, m_tdata, m_tlast);
	end

	// Watchdog: a block that stops moving data in either direction ends the run.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts, and once a long hold-off that lets the token queue
	// fill so that the scanner has to hold back its input.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
				holds_done++;
			end else if ($urandom_range(0, 99) < sink_gap) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// One input transfer. tvalid is left high on return, so that back-to-back items keep it
	// high; an idle burst, where there is one, lowers it at the start of the next call.
	task automatic put_byte(input logic [7:0] b, input logic has, input logic fin);
		if ($urandom_range(0, 99) < src_gap) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= has;
		s_tlast  <= fin;
		items_sent++;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i], 1'b1, 1'b0);
	endtask

	function automatic logic [7:0] word_char();
		case ($urandom_range(0, 6))
			0, 1, 2: return 8'($urandom_range(8'h61, 8'h7A));
			3:       return 8'($urandom_range(8'h41, 8'h5A));
			4, 5:    return 8'($urandom_range(8'h30, 8'h39));
			default: return CH_UNDER;
		endcase
	endfunction

	// Anything but a closing quote, with newlines made common.
	function automatic logic [7:0] string_char();
		logic [7:0] b;
		if ($urandom_range(0, 3) == 0)
			return CH_NEWLINE;
		do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
		return b;
	endfunction

	function automatic void add_lexeme(ref logic [7:0] text[$]);
		string w;
		case ($urandom_range(0, 11))
			0: begin
				w = keywords[$urandom_range(0, 4)];
				for (int i = 0; i < w.len(); i++)
					text.insert(text.size(), w[i]);
				// Sometimes spoil it, which also gives identifiers longer than a keyword.
				if ($urandom_range(0, 3) == 0)
					text.insert(text.size(), word_char());
			end
			1, 2: begin
				text.insert(text.size(), ($urandom_range(0, 4) == 0) ? CH_UNDER
					: 8'($urandom_range(8'h61, 8'h7A)));
				repeat ($urandom_range(0, 8))
					text.insert(text.size(), word_char());
			end
			3, 4: begin
				repeat ($urandom_range(1, 5))
					text.insert(text.size(), 8'($urandom_range(8'h30, 8'h39)));
				if ($urandom_range(0, 1)) begin
					text.insert(text.size(), CH_DOT);
					repeat ($urandom_range(0, 3))
						text.insert(text.size(), 8'($urandom_range(8'h30, 8'h39)));
				end
			end
			5: begin
				text.insert(text.size(), CH_QUOTE);
				repeat ($urandom_range(0, 8))
					text.insert(text.size(), string_char());
				text.insert(text.size(), CH_QUOTE);
			end
			6, 7:    text.insert(text.size(), op_chars[$urandom_range(0, 9)]);
			8, 9:    text.insert(text.size(), ($urandom_range(0, 5) == 0) ? 8'h20
					: 8'($urandom_range(9, 13)));
			10:      text.insert(text.size(), 8'($urandom_range(0, 255)));
			default: text.insert(text.size(), 8'($urandom_range(128, 255)));
		endcase
		if ($urandom_range(0, 1))
			text.insert(text.size(), 8'h20);
	endfunction

	// A whole source of random lexemes. Some are left inside an open string, and the end
	// comes either with the last byte or as a transfer that carries no byte.
	task automatic send_source(input int lexemes);
		logic [7:0] text[$];
		bit         empty_end;
		for (int i = 0; i < lexemes; i++)
			add_lexeme(text);
		if ($urandom_range(0, 5) == 0) begin
			text.insert(text.size(), CH_QUOTE);
			repeat ($urandom_range(0, 3))
				text.insert(text.size(), string_char());
		end
		empty_end = (text.size() == 0) || ($urandom_range(0, 1) == 1);
		foreach (text[i]) begin
			if ($urandom_range(0, 15) == 0)
				put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			put_byte(text[i], 1'b1, !empty_end && i == text.size() - 1);
		end
		if (empty_end)
			put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with idling on both sides.
		src_gap  = 30;
		sink_gap = 30;
		// Keyword, operators, an identifier with underscore and digit, a number ending in a
		// dot closed by an operator, then an end carried by an empty transfer.
		put_text("if(_9,2.)");
		put_byte(8'hA5, 1'b0, 1'b1);
		// A string across a newline left open at the end gives the error token.
		put_text("{\"");
		put_byte(CH_NEWLINE, 1'b1, 1'b0);
		put_byte("q", 1'b1, 1'b0);
		put_byte(8'h5A, 1'b0, 1'b1);
		// An empty transfer, an unknown top byte and a NUL, then an identifier closed by an
		// operator on the last byte: three tokens from one transfer.
		put_byte(8'hFF, 1'b0, 1'b0);
		put_byte(8'hFF, 1'b1, 1'b0);
		put_byte(8'h00, 1'b1, 1'b0);
		put_byte("z", 1'b1, 1'b0);
		put_byte("}", 1'b1, 1'b1);
		put_text("7.");
		put_byte("/", 1'b1, 1'b1);

		// Random sources, each with its own idling mix so that quiet stretches also occur.
		while (items_sent < 300) begin
			src_gap  = $urandom_range(0, 2) == 0 ? 0 : 25;
			sink_gap = $urandom_range(0, 2) == 0 ? 0 : 25;
			send_source($urandom_range(1, 14));
		end

		// The receiver holds off while the sender keeps offering, until the scanner stalls.
		src_gap  = 0;
		sink_gap = 0;
		hold_off = 1'b1;
		send_source(30);

		// Last part without any idling.
		while (items_sent < RANDOM_ITEMS)
			send_source($urandom_range(1, 14));
		s_tvalid <= 1'b0;

		while (sb.expected_tokens.size() != 0 || hold_off)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("Scanned %0d bytes in %0d sources; %0d tokens checked, %0d kinds seen, %0d open strings.",
			sb.bytes_seen, sb.sources_seen, sb.tokens_checked, $countones(sb.kinds_seen),
			sb.unterminated_seen);
		$display("Idling ran on both sides and the input was stalled by %0d long hold-off.",
			holds_done);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
